/* hw/rtl/vbr_pkg.sv */
`timescale 1ns / 1ps

package vbr_pkg;

  localparam int TOC_ENTRIES = 100;
  localparam int TOC_AW = 7;
  localparam logic [TOC_AW-1:0] TOC_LAST = 7'd99;
  localparam logic [TOC_AW-1:0] TOC_COUNT = 7'd100;
  localparam logic [14:0] PCT_MAX = 15'd25599;

  // The two accepted four-byte header identifiers.
  localparam logic [7:0] ID_A [4] = '{8'h58, 8'h69, 8'h6E, 8'h67};
  localparam logic [7:0] ID_B [4] = '{8'h49, 8'h6E, 8'h66, 8'h6F};

  typedef enum logic [1:0] {
    KIND_DONE   = 2'd0,
    KIND_REJECT = 2'd1,
    KIND_SEEK   = 2'd2,
    KIND_NOTOC  = 2'd3
  } kind_t;

  typedef struct packed {
    logic              restart;
    logic              shift_en;
    logic              shift_clr;
    logic              load_flags;
    logic              load_frames;
    logic              load_bytes;
    logic              load_qual;
    logic              toc_wr;
    logic [TOC_AW-1:0] toc_idx;
    logic [1:0]        id_idx;
    logic              seek_start;
    logic              fx_en;
    logic              res_load;
    logic              res_seek;
    kind_t             res_kind;
  } cmd_t;

  typedef struct packed {
    logic [1:0] id_eq;
    logic [3:0] flag_bits;
    logic [3:0] flags;
    logic       res_busy;
  } status_t;

endpackage

/* hw/rtl/vbr_if.sv */
`timescale 1ns / 1ps

interface vbr_in_if;
  logic        valid;
  logic        ready;
  logic        op;
  logic [7:0]  data_byte;
  logic        first_byte;
  logic [14:0] percent;

  modport source (output valid, output op, output data_byte, output first_byte,
                  output percent, input ready);
  modport sink (input valid, input op, input data_byte, input first_byte,
                input percent, output ready);
endinterface

interface vbr_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  kind;
  logic [31:0] position;
  logic [31:0] frame_count;
  logic [31:0] byte_count;
  logic [31:0] quality;
  logic [3:0]  present_flags;

  modport source (output valid, output kind, output position, output frame_count,
                  output byte_count, output quality, output present_flags,
                  input ready);
  modport sink (input valid, input kind, input position, input frame_count,
                input byte_count, input quality, input present_flags,
                output ready);
endinterface

/* hw/rtl/vbr_ram.sv */
`timescale 1ns / 1ps

module vbr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 100
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr_a,
  input  logic [$clog2(DEPTH)-1:0] raddr_b,
  output logic [WIDTH-1:0]         rdata_a,
  output logic [WIDTH-1:0]         rdata_b
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_a <= mem[raddr_a];
    rdata_b <= mem[raddr_b];
  end

endmodule

/* hw/rtl/vbr_ctrl.sv */
`timescale 1ns / 1ps

module vbr_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  input  logic             op,
  input  logic             first_byte,
  output logic             in_ready,
  input  vbr_pkg::status_t status,
  output vbr_pkg::cmd_t    cmd
);

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_FX   = 3'b010,
    ST_MUL  = 3'b100
  } state_t;

  typedef enum logic [7:0] {
    PH_ID     = 8'b0000_0001,
    PH_FLAGS  = 8'b0000_0010,
    PH_FRAMES = 8'b0000_0100,
    PH_BYTES  = 8'b0000_1000,
    PH_TOC    = 8'b0001_0000,
    PH_QUAL   = 8'b0010_0000,
    PH_DONE   = 8'b0100_0000,
    PH_REJ    = 8'b1000_0000
  } phase_t;

  state_t                    state, state_next;
  phase_t                    phase, phase_next;
  logic [vbr_pkg::TOC_AW-1:0] field_count, field_count_next;
  logic [1:0]                id_match, id_match_next;
  logic                      toc_valid, toc_valid_next;

  phase_t                    ph;
  phase_t                    ph_after;
  logic [vbr_pkg::TOC_AW-1:0] fc;
  logic [vbr_pkg::TOC_AW-1:0] fc_inc;
  logic [1:0]                im;
  logic                      accept;

  // First optional field flagged at or after the given field slot.
  function automatic phase_t next_present(input logic [1:0] start, input logic [3:0] flags);
    phase_t res;
    priority if (start == 2'd0 && flags[0]) res = PH_FRAMES;
    else if (start <= 2'd1 && flags[1]) res = PH_BYTES;
    else if (start <= 2'd2 && flags[2]) res = PH_TOC;
    else if (flags[3]) res = PH_QUAL;
    else res = PH_DONE;
    return res;
  endfunction

  assign in_ready = (state == ST_IDLE) && !status.res_busy;
  assign accept   = in_valid && in_ready;

  always_comb begin
    cmd              = '0;
    state_next       = state;
    phase_next       = phase;
    field_count_next = field_count;
    id_match_next    = id_match;
    toc_valid_next   = toc_valid;
    ph               = phase;
    fc               = field_count;
    im               = id_match;
    ph_after         = PH_DONE;
    if (accept && !op && first_byte) begin
      ph             = PH_ID;
      fc             = '0;
      im             = 2'b11;
      toc_valid_next = 1'b0;
      cmd.restart    = 1'b1;
    end
    fc_inc      = fc + 7'd1;
    cmd.id_idx  = fc[1:0];
    cmd.toc_idx = fc;

    unique case (state)
      ST_IDLE: begin
        if (accept) begin
          if (op) begin
            if (!toc_valid) begin
              cmd.res_load = 1'b1;
              cmd.res_kind = vbr_pkg::KIND_NOTOC;
            end else begin
              cmd.seek_start = 1'b1;
              state_next     = ST_FX;
            end
          end else begin
            phase_next       = ph;
            field_count_next = fc;
            id_match_next    = im;
            unique case (ph)
              PH_ID: begin
                id_match_next    = im & status.id_eq;
                field_count_next = fc_inc;
                if (id_match_next == 2'b00) begin
                  phase_next   = PH_REJ;
                  cmd.res_load = 1'b1;
                  cmd.res_kind = vbr_pkg::KIND_REJECT;
                end else if (fc_inc == 7'd4) begin
                  phase_next       = PH_FLAGS;
                  field_count_next = '0;
                end
              end
              PH_FLAGS, PH_FRAMES, PH_BYTES, PH_QUAL: begin
                cmd.shift_en     = 1'b1;
                field_count_next = fc_inc;
                if (fc_inc == 7'd4) begin
                  field_count_next = '0;
                  cmd.shift_clr    = 1'b1;
                  priority if (ph == PH_FLAGS) begin
                    cmd.load_flags = 1'b1;
                    ph_after       = next_present(2'd0, status.flag_bits);
                  end else if (ph == PH_FRAMES) begin
                    cmd.load_frames = 1'b1;
                    ph_after        = next_present(2'd1, status.flags);
                  end else if (ph == PH_BYTES) begin
                    cmd.load_bytes = 1'b1;
                    ph_after       = next_present(2'd2, status.flags);
                  end else begin
                    cmd.load_qual = 1'b1;
                    ph_after      = PH_DONE;
                  end
                  phase_next = ph_after;
                  if (ph_after == PH_DONE) begin
                    cmd.res_load = 1'b1;
                    cmd.res_kind = vbr_pkg::KIND_DONE;
                  end
                end
              end
              PH_TOC: begin
                cmd.toc_wr       = 1'b1;
                field_count_next = fc_inc;
                if (fc_inc == vbr_pkg::TOC_COUNT) begin
                  toc_valid_next   = 1'b1;
                  field_count_next = '0;
                  if (status.flags[3]) begin
                    phase_next = PH_QUAL;
                  end else begin
                    phase_next   = PH_DONE;
                    cmd.res_load = 1'b1;
                    cmd.res_kind = vbr_pkg::KIND_DONE;
                  end
                end
              end
              PH_DONE, PH_REJ: begin
              end
              default: begin
                phase_next = PH_REJ;
              end
            endcase
          end
        end
      end
      ST_FX: begin
        cmd.fx_en  = 1'b1;
        state_next = ST_MUL;
      end
      ST_MUL: begin
        cmd.res_load = 1'b1;
        cmd.res_seek = 1'b1;
        cmd.res_kind = vbr_pkg::KIND_SEEK;
        state_next   = ST_IDLE;
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_IDLE;
      phase       <= PH_ID;
      field_count <= '0;
      id_match    <= 2'b11;
      toc_valid   <= 1'b0;
    end else begin
      state       <= state_next;
      phase       <= phase_next;
      field_count <= field_count_next;
      id_match    <= id_match_next;
      toc_valid   <= toc_valid_next;
    end
  end

endmodule

/* hw/rtl/vbr_dp.sv */
`timescale 1ns / 1ps

module vbr_dp (
  input  logic             clk,
  input  logic             rst,
  input  logic [7:0]       data_byte,
  input  logic [14:0]      percent,
  input  vbr_pkg::cmd_t    cmd,
  output vbr_pkg::status_t status,
  vbr_out_if.source        result
);

  logic [31:0] shift_word, shift_word_next;
  logic [31:0] shifted;
  logic [3:0]  flags_kept, flags_next;
  logic [31:0] frames_kept, frames_next;
  logic [31:0] bytes_kept, bytes_next;
  logic [31:0] quality_kept, quality_next;

  logic [14:0]                pct_sat;
  logic [vbr_pkg::TOC_AW-1:0] seek_a;
  logic [vbr_pkg::TOC_AW-1:0] seek_b;
  logic [7:0]                 toc_cur;
  logic [7:0]                 toc_nxt;
  logic [7:0]                 frac;
  logic                       last;
  logic [8:0]                 nxt9;
  logic [8:0]                 wgt;
  logic [16:0]                part_cur;
  logic [16:0]                part_nxt;
  logic [16:0]                fx_sum;
  logic [15:0]                fx;
  logic [47:0]                prod;

  logic                 res_valid;
  vbr_pkg::kind_t       res_kind;
  logic [31:0]          res_position;
  logic [31:0]          res_frames;
  logic [31:0]          res_bytes;
  logic [31:0]          res_quality;
  logic [3:0]           res_flags;
  logic                 out_valid;
  vbr_pkg::kind_t       out_kind;
  logic [31:0]          out_position;
  logic [31:0]          out_frames;
  logic [31:0]          out_bytes;
  logic [31:0]          out_quality;
  logic [3:0]           out_flags;
  logic                 out_take;

  // Header field assembly, big-endian.
  always_comb begin
    shifted         = {(cmd.restart ? 24'd0 : shift_word[23:0]), data_byte};
    shift_word_next = shift_word;
    if (cmd.restart) begin
      shift_word_next = '0;
    end
    if (cmd.shift_clr) begin
      shift_word_next = '0;
    end else if (cmd.shift_en) begin
      shift_word_next = shifted;
    end
    flags_next   = cmd.restart ? 4'd0 : (cmd.load_flags ? shifted[3:0] : flags_kept);
    frames_next  = cmd.restart ? 32'd0 : (cmd.load_frames ? shifted : frames_kept);
    bytes_next   = cmd.restart ? 32'd0 : (cmd.load_bytes ? shifted : bytes_kept);
    quality_next = cmd.restart ? 32'd0 : (cmd.load_qual ? shifted : quality_kept);
  end

  assign status.id_eq     = {data_byte == vbr_pkg::ID_B[cmd.id_idx],
                             data_byte == vbr_pkg::ID_A[cmd.id_idx]};
  assign status.flag_bits = data_byte[3:0];
  assign status.flags     = flags_kept;
  assign status.res_busy  = res_valid;

  // Seek: the table entry and its successor are read together; past the
  // last entry the successor is the constant 256.
  assign pct_sat = (percent > vbr_pkg::PCT_MAX) ? vbr_pkg::PCT_MAX : percent;
  assign seek_a  = pct_sat[14:8];
  assign seek_b  = (seek_a == vbr_pkg::TOC_LAST) ? seek_a : seek_a + 7'd1;

  vbr_ram #(
    .WIDTH (8),
    .DEPTH (vbr_pkg::TOC_ENTRIES)
  ) u_toc (
    .clk     (clk),
    .we      (cmd.toc_wr),
    .waddr   (cmd.toc_idx),
    .wdata   (data_byte),
    .raddr_a (seek_a),
    .raddr_b (seek_b),
    .rdata_a (toc_cur),
    .rdata_b (toc_nxt)
  );

  assign nxt9     = last ? 9'd256 : {1'b0, toc_nxt};
  assign wgt      = 9'd256 - {1'b0, frac};
  assign part_cur = 17'(toc_cur) * 17'(wgt);
  assign part_nxt = 17'(nxt9) * 17'(frac);
  assign fx_sum   = part_cur + part_nxt;
  assign prod     = 48'(fx) * 48'(bytes_kept);

  assign out_take = !out_valid || result.ready;

  always_ff @(posedge clk) begin
    if (cmd.seek_start) begin
      frac <= pct_sat[7:0];
      last <= (seek_a == vbr_pkg::TOC_LAST);
    end
    if (cmd.fx_en) begin
      fx <= fx_sum[15:0];
    end
    if (cmd.res_load) begin
      res_kind     <= cmd.res_kind;
      res_position <= cmd.res_seek ? prod[47:16] : 32'd0;
      res_frames   <= frames_next;
      res_bytes    <= bytes_next;
      res_quality  <= quality_next;
      res_flags    <= flags_next;
    end
    if (res_valid && out_take) begin
      out_kind     <= res_kind;
      out_position <= res_position;
      out_frames   <= res_frames;
      out_bytes    <= res_bytes;
      out_quality  <= res_quality;
      out_flags    <= res_flags;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      shift_word   <= '0;
      flags_kept   <= '0;
      frames_kept  <= '0;
      bytes_kept   <= '0;
      quality_kept <= '0;
      res_valid    <= 1'b0;
      out_valid    <= 1'b0;
    end else begin
      shift_word   <= shift_word_next;
      flags_kept   <= flags_next;
      frames_kept  <= frames_next;
      bytes_kept   <= bytes_next;
      quality_kept <= quality_next;
      if (cmd.res_load) begin
        res_valid <= 1'b1;
      end else if (out_take) begin
        res_valid <= 1'b0;
      end
      if (res_valid && out_take) begin
        out_valid <= 1'b1;
      end else if (result.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  assign result.valid         = out_valid;
  assign result.kind          = out_kind;
  assign result.position      = out_position;
  assign result.frame_count   = out_frames;
  assign result.byte_count    = out_bytes;
  assign result.quality       = out_quality;
  assign result.present_flags = out_flags;

endmodule

/* hw/rtl/vbr_toc_header_seek.sv */
`timescale 1ns / 1ps

// Channel   Direction  Transaction
// item      in         op, data_byte, first_byte, percent
// result    out        kind, position, frame_count, byte_count, quality, present_flags
//
// A header byte is handled in the cycle it is accepted; a seek query passes three
// steps (table read, interpolation register, 16 x 32 multiply), set by the registered
// table read and the two dependent multiplies; no new item is taken until it ends.
// Every result passes a one-entry staging register and then the output register,
// so a result-producing transaction holds off the next one until staging has emptied.
// Synchronous reset clears the parser to the identifier phase; the table
// contents are not cleared and are only read once all entries have been written.
// A stalled result stage stops input; the output register alone does not.
module vbr_toc_header_seek (
  input logic        clk,
  input logic        rst,
  vbr_in_if.sink     item,
  vbr_out_if.source  result
);

  vbr_pkg::cmd_t    cmd;
  vbr_pkg::status_t status;

  vbr_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (item.valid),
    .op         (item.op),
    .first_byte (item.first_byte),
    .in_ready   (item.ready),
    .status     (status),
    .cmd        (cmd)
  );

  vbr_dp u_dp (
    .clk       (clk),
    .rst       (rst),
    .data_byte (item.data_byte),
    .percent   (item.percent),
    .cmd       (cmd),
    .status    (status),
    .result    (result)
  );

endmodule

/* dv/testbench.sv */
`timescale 1ns / 1ps

module testbench;

  localparam logic OP_BYTE = 1'b0;
  localparam logic OP_SEEK = 1'b1;
  localparam int RANDOM_ITEMS = 1100;
  localparam int CALM_ITEMS = 950;

  typedef enum logic [2:0] {
    HDR_IDENT    = 3'd0,
    HDR_FLAGS    = 3'd1,
    HDR_FRAMES   = 3'd2,
    HDR_BYTES    = 3'd3,
    HDR_TOC      = 3'd4,
    HDR_QUALITY  = 3'd5,
    HDR_DONE     = 3'd6,
    HDR_REJECTED = 3'd7
  } hdr_phase_t;

  typedef enum logic [1:0] {
    TOC_RAMP,
    TOC_MONO,
    TOC_NOISE
  } toc_shape_t;

  typedef struct packed {
    vbr_pkg::kind_t kind;
    logic [31:0]    position;
    logic [31:0]    frames;
    logic [31:0]    bytes;
    logic [31:0]    quality;
    logic [3:0]     flags;
  } vbr_result_t;

  logic clk;
  logic rst;

  vbr_in_if  item_bus ();
  vbr_out_if result_bus ();

  vbr_toc_header_seek dut (
    .clk    (clk),
    .rst    (rst),
    .item   (item_bus),
    .result (result_bus)
  );

  // Parser state as the block should hold it.
  hdr_phase_t  hdr_phase;
  int          field_idx;
  logic [31:0] word_acc;
  logic [1:0]  id_live;
  logic [3:0]  flags_kept;
  logic [31:0] frames_kept;
  logic [31:0] bytes_kept;
  logic [31:0] quality_kept;
  logic [7:0]  toc_seen [vbr_pkg::TOC_ENTRIES];
  bit          toc_full;

  vbr_result_t results_due [$];
  vbr_result_t head_result;
  logic [7:0]  hdr_seq [$];
  logic [7:0]  toc_plan [vbr_pkg::TOC_ENTRIES];
  int          errors;
  int          useful_items;
  bit          calm;

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  initial begin
    #10_000_000;
    $display("vbr_toc_header_seek: mismatch");
    $finish;
  end

  function automatic vbr_result_t snapshot(vbr_pkg::kind_t k, logic [31:0] pos);
    vbr_result_t r;
    r.kind = k;
    r.position = pos;
    r.frames = frames_kept;
    r.bytes = bytes_kept;
    r.quality = quality_kept;
    r.flags = flags_kept;
    return r;
  endfunction

  function automatic hdr_phase_t next_field(hdr_phase_t from);
    hdr_phase_t p;
    p = from;
    while (p != HDR_DONE) begin
      if (flags_kept[p - HDR_FRAMES]) return p;
      p = hdr_phase_t'(p + 1);
    end
    return HDR_DONE;
  endfunction

  task automatic restart_parse();
    hdr_phase = HDR_IDENT;
    field_idx = 0;
    word_acc = '0;
    id_live = 2'b11;
    flags_kept = '0;
    frames_kept = '0;
    bytes_kept = '0;
    quality_kept = '0;
    toc_full = 1'b0;
  endtask

  task automatic parse_and_seek(input logic op_in, input logic [7:0] b, input logic first,
                                input logic [14:0] pct);
    logic [14:0]     pc;
    int unsigned     seg;
    int unsigned     frac;
    int unsigned     cur;
    int unsigned     nxt;
    longint unsigned fx;
    longint unsigned prod;
    if (op_in == OP_SEEK) begin
      useful_items++;
      if (!toc_full) begin
        results_due.push_back(snapshot(vbr_pkg::KIND_NOTOC, '0));
      end else begin
        pc = (pct > vbr_pkg::PCT_MAX) ? vbr_pkg::PCT_MAX : pct;
        seg = pc[14:8];
        frac = pc[7:0];
        cur = toc_seen[seg];
        nxt = (seg + 1 < vbr_pkg::TOC_ENTRIES) ? toc_seen[seg + 1] : 256;
        fx = cur * (256 - frac) + nxt * frac;
        prod = fx * bytes_kept;
        results_due.push_back(snapshot(vbr_pkg::KIND_SEEK, prod[47:16]));
      end
    end else begin
      if (first) restart_parse();
      if (hdr_phase != HDR_DONE && hdr_phase != HDR_REJECTED) useful_items++;
      case (hdr_phase)
        HDR_IDENT: begin
          if (b != vbr_pkg::ID_A[field_idx]) id_live[0] = 1'b0;
          if (b != vbr_pkg::ID_B[field_idx]) id_live[1] = 1'b0;
          field_idx++;
          if (id_live == 2'b00) begin
            hdr_phase = HDR_REJECTED;
            results_due.push_back(snapshot(vbr_pkg::KIND_REJECT, '0));
          end else if (field_idx == 4) begin
            hdr_phase = HDR_FLAGS;
            field_idx = 0;
          end
        end
        HDR_FLAGS, HDR_FRAMES, HDR_BYTES, HDR_QUALITY: begin
          word_acc = {word_acc[23:0], b};
          field_idx++;
          if (field_idx == 4) begin
            case (hdr_phase)
              HDR_FLAGS:  flags_kept = word_acc[3:0];
              HDR_FRAMES: frames_kept = word_acc;
              HDR_BYTES:  bytes_kept = word_acc;
              default:    quality_kept = word_acc;
            endcase
            field_idx = 0;
            word_acc = '0;
            hdr_phase = next_field((hdr_phase == HDR_FLAGS) ? HDR_FRAMES
                                                            : hdr_phase_t'(hdr_phase + 1));
            if (hdr_phase == HDR_DONE) begin
              results_due.push_back(snapshot(vbr_pkg::KIND_DONE, '0));
            end
          end
        end
        HDR_TOC: begin
          toc_seen[field_idx] = b;
          field_idx++;
          if (field_idx == vbr_pkg::TOC_ENTRIES) begin
            toc_full = 1'b1;
            field_idx = 0;
            hdr_phase = next_field(HDR_QUALITY);
            if (hdr_phase == HDR_DONE) begin
              results_due.push_back(snapshot(vbr_pkg::KIND_DONE, '0));
            end
          end
        end
        default: ;
      endcase
    end
  endtask

  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
    if (got !== want) begin
      $display("%0t: %s expected %h actual %h", $time, name, want, got);
      errors++;
    end
  endtask

  always @(posedge clk) begin
    if (!rst && result_bus.valid && result_bus.ready) begin
      if (results_due.size() == 0) begin
        $display("%0t: kind expected none actual %0d", $time, result_bus.kind);
        errors++;
      end else begin
        head_result = results_due.pop_front();
        check_field("kind", head_result.kind, result_bus.kind);
        check_field("position", head_result.position, result_bus.position);
        check_field("frame_count", head_result.frames, result_bus.frame_count);
        check_field("byte_count", head_result.bytes, result_bus.byte_count);
        check_field("quality", head_result.quality, result_bus.quality);
        check_field("present_flags", head_result.flags, result_bus.present_flags);
      end
    end
  end

  // Result side back-pressure: stall bursts between runs of readiness.
  initial begin
    result_bus.ready <= 1'b0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      if (!calm && $urandom_range(0, 3) == 0) begin
        result_bus.ready <= 1'b0;
        repeat ($urandom_range(1, 17)) @(posedge clk);
      end
      result_bus.ready <= 1'b1;
      repeat ($urandom_range(1, 30)) @(posedge clk);
    end
  end

  task automatic send_item(input logic op_in, input logic [7:0] b, input logic first,
                           input logic [14:0] pct);
    if (!calm && $urandom_range(0, 7) == 0) begin
      item_bus.valid <= 1'b0;
      repeat ($urandom_range(1, 17)) @(posedge clk);
    end
    item_bus.valid <= 1'b1;
    item_bus.op <= op_in;
    item_bus.data_byte <= b;
    item_bus.first_byte <= first;
    item_bus.percent <= pct;
    do @(posedge clk); while (!item_bus.ready);
    parse_and_seek(op_in, b, first, pct);
  endtask

  task automatic send_byte(input logic [7:0] b, input logic first);
    send_item(OP_BYTE, b, first, 15'($urandom_range(0, 32767)));
  endtask

  task automatic send_seek(input logic [14:0] pct);
    send_item(OP_SEEK, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)), pct);
  endtask

  // Holds the sender off until every outstanding result has been taken.
  task automatic wait_drained();
    item_bus.valid <= 1'b0;
    while (results_due.size() != 0) @(posedge clk);
  endtask

  function automatic logic [14:0] pick_percent();
    case ($urandom_range(0, 5))
      0:       return 15'($urandom_range(0, 32767));
      1:       return 15'($urandom_range(25344, 25599));
      2:       return 15'($urandom_range(0, 255));
      default: return 15'($urandom_range(0, 25599));
    endcase
  endfunction

  function automatic logic [31:0] pick_word();
    case ($urandom_range(0, 5))
      0:       return '0;
      1:       return '1;
      2:       return 32'($urandom_range(0, 65535));
      default: return $urandom;
    endcase
  endfunction

  task automatic plan_toc(input toc_shape_t shape);
    int level;
    level = 0;
    for (int i = 0; i < vbr_pkg::TOC_ENTRIES; i++) begin
      case (shape)
        TOC_RAMP: toc_plan[i] = 8'(i * 255 / (vbr_pkg::TOC_ENTRIES - 1));
        TOC_MONO: begin
          level = level + $urandom_range(0, 5);
          if (level > 255) level = 255;
          toc_plan[i] = 8'(level);
        end
        default:  toc_plan[i] = 8'($urandom_range(0, 255));
      endcase
    end
  endtask

  task automatic append_word(input logic [31:0] w);
    for (int k = 3; k >= 0; k--) hdr_seq.push_back(w[8*k +: 8]);
  endtask

  // Sends a header built from its fields and the planned TOC. A nonnegative cut
  // truncates it; seek_odds above zero scatters seeks through it.
  task automatic send_header(input bit ident_a, input logic [31:0] flags_word,
                             input logic [31:0] frames_w, input logic [31:0] bytes_w,
                             input logic [31:0] qual_w, input int cut, input int seek_odds);
    hdr_seq.delete();
    for (int i = 0; i < 4; i++) hdr_seq.push_back(ident_a ? vbr_pkg::ID_A[i] : vbr_pkg::ID_B[i]);
    append_word(flags_word);
    if (flags_word[0]) append_word(frames_w);
    if (flags_word[1]) append_word(bytes_w);
    if (flags_word[2]) begin
      for (int i = 0; i < vbr_pkg::TOC_ENTRIES; i++) hdr_seq.push_back(toc_plan[i]);
    end
    if (flags_word[3]) append_word(qual_w);
    for (int i = 0; i < hdr_seq.size() && (cut < 0 || i < cut); i++) begin
      if (seek_odds > 0 && $urandom_range(1, seek_odds) == 1) send_seek(pick_percent());
      send_byte(hdr_seq[i], i == 0);
    end
  endtask

  task automatic test_seek_without_toc();
    send_seek(15'd0);
    send_seek(15'd32767);
  endtask

  task automatic test_identifier_reject();
    send_byte(8'h00, 1'b1);
    send_byte(vbr_pkg::ID_A[0], 1'b1);
    send_byte(8'h00, 1'b0);
    send_byte(vbr_pkg::ID_B[0], 1'b1);
    send_byte(vbr_pkg::ID_B[1], 1'b0);
    send_byte(vbr_pkg::ID_B[2], 1'b0);
    send_byte(8'hFF, 1'b0);
    // Bytes after a reject are dropped until the next restart.
    send_byte(vbr_pkg::ID_B[3], 1'b0);
    send_byte(vbr_pkg::ID_A[0], 1'b1);
    send_byte(vbr_pkg::ID_A[1], 1'b0);
    send_header(1'b0, 32'h0000_0000, '0, '0, '0, -1, 0);
  endtask

  task automatic test_flags_only();
    send_header(1'b1, 32'hFFFF_FFF0, '0, '0, '0, -1, 0);
    send_byte(8'hA5, 1'b0);
    send_seek(15'd12800);
  endtask

  task automatic test_full_header();
    plan_toc(TOC_RAMP);
    send_header(1'b1, 32'h0000_000F, '1, '1, '1, -1, 30);
    wait_drained();
    send_seek(15'd0);
    send_seek(15'd255);
    send_seek(15'd256);
    send_seek(15'd25343);
    send_seek(15'd25344);
    send_seek(15'd25599);
    send_seek(15'd25600);
    send_seek(15'd32767);
  endtask

  task automatic test_partial_flags();
    plan_toc(TOC_NOISE);
    // A TOC without a byte count makes every seek land on zero.
    send_header(1'b0, 32'h0000_0004, '0, '0, '0, -1, 0);
    send_seek(15'd16383);
    send_header(1'b1, 32'h0000_0003, 32'h1234_5678, 32'h0001_0000, '0, -1, 0);
    send_seek(15'd100);
    send_header(1'b0, 32'h8000_0008, '0, '0, 32'hDEAD_BEEF, -1, 0);
  endtask

  task automatic test_random_traffic();
    int          start;
    int          pick;
    int          total;
    logic [31:0] flags_word;
    start = useful_items;
    while (useful_items - start < RANDOM_ITEMS) begin
      if (useful_items - start >= CALM_ITEMS) calm = 1'b1;
      pick = $urandom_range(0, 99);
      flags_word = ($urandom_range(0, 1) ? $urandom : 32'd0) & 32'hFFFF_FFF0;
      flags_word[3:0] = 4'($urandom_range(0, 15));
      if (pick < 65 || pick < 75) begin
        plan_toc(toc_shape_t'($urandom_range(0, 2)));
        total = 8 + 4 * (flags_word[0] + flags_word[1] + flags_word[3])
                + vbr_pkg::TOC_ENTRIES * flags_word[2];
        send_header(1'($urandom_range(0, 1)), flags_word, pick_word(), pick_word(),
                    pick_word(), (pick < 65) ? -1 : $urandom_range(1, total - 1), 40);
        if (pick < 65) repeat ($urandom_range(1, 6)) send_seek(pick_percent());
      end else if (pick < 85) begin
        repeat ($urandom_range(1, 8)) begin
          if ($urandom_range(0, 1)) send_byte(vbr_pkg::ID_A[$urandom_range(0, 3)],
                                              $urandom_range(0, 3) == 0);
          else send_byte(8'($urandom_range(0, 255)), $urandom_range(0, 3) == 0);
        end
      end else begin
        repeat ($urandom_range(1, 8)) send_seek(pick_percent());
      end
      if (!calm && $urandom_range(0, 14) == 0) wait_drained();
    end
  endtask

  initial begin
    errors = 0;
    useful_items = 0;
    calm = 1'b0;
    restart_parse();
    rst <= 1'b1;
    item_bus.valid <= 1'b0;
    item_bus.op <= OP_BYTE;
    item_bus.data_byte <= '0;
    item_bus.first_byte <= 1'b0;
    item_bus.percent <= '0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    test_seek_without_toc();
    test_identifier_reject();
    test_flags_only();
    test_full_header();
    test_partial_flags();
    test_random_traffic();

    wait_drained();
    repeat (10) @(posedge clk);
    if (errors == 0 && results_due.size() == 0) begin
      $display("vbr_toc_header_seek: match");
    end else begin
      $display("vbr_toc_header_seek: mismatch");
    end
    $finish;
  end

endmodule
